// ===== rtl/bctbd_pkg.sv =====
// ----------------------------------------------------------------------------
// bctbd_pkg
// Shared codes, widths and structures of the BC1..BC5 block decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bctbd_pkg;

  // format register codes
  localparam logic [2:0] FMT_BC1 = 3'd0;
  localparam logic [2:0] FMT_BC2 = 3'd1;
  localparam logic [2:0] FMT_BC3 = 3'd2;
  localparam logic [2:0] FMT_BC4 = 3'd3;
  localparam logic [2:0] FMT_BC5 = 3'd4;

  localparam int LANES = 4;     // texel columns decoded side by side
  localparam int IN_W  = 128;   // block_low, block_high
  localparam int OUT_W = 136;   // row_index + four texels, padded to bytes

  // first pipeline stage: expanded endpoints and weighted sums
  typedef struct packed {
    logic                  three;   // BC1 three-color mode
    logic [1:0][2:0][7:0]  ep;      // endpoint colors, [2] red .. [0] blue
    logic [2:0][9:0]       s2;      // 2*c0 + c1 per channel
    logic [2:0][9:0]       s3;      // c0 + 2*c1 per channel
  } csum_t;

  typedef struct packed {
    logic                  gt;      // e0 > e1: eight-value mode
    logic [7:0]            e0;
    logic [7:0]            e1;
    logic [5:0][10:0]      sum;     // weighted endpoint sums of entries 2..7
  } vsum_t;

  typedef struct packed {
    csum_t c;
    vsum_t a;
    vsum_t g;
  } psum_t;

  // second pipeline stage: finished palettes
  typedef struct packed {
    logic                  trans;   // entry 3 is transparent black
    logic [3:0][23:0]      rgb;
  } cpal_t;

  typedef struct packed {
    cpal_t                 c;
    logic [7:0][7:0]       a;       // palette from block_low
    logic [7:0][7:0]       g;       // palette from block_high
  } pal_t;

  // index bits that one lane needs for its texel
  typedef struct packed {
    logic [1:0] cidx;
    logic [3:0] a4;
    logic [2:0] aidx;
    logic [2:0] gidx;
  } tidx_t;

endpackage

`default_nettype wire

// ===== rtl/bctbd_palette.sv =====
// ----------------------------------------------------------------------------
// bctbd_palette
// Two-stage palette builder: endpoint expansion and weighted sums, then the
// reciprocal divides by 3, 5 and 7.
// ----------------------------------------------------------------------------
`default_nettype none

module bctbd_palette
  import bctbd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [2:0]  fmt,
  input  wire logic [63:0] blk_lo,
  input  wire logic [63:0] blk_hi,
  input  wire logic        s1_en,
  input  wire logic        s2_en,
  output      pal_t        pal
);

  psum_t sum_nxt, sum_r;
  pal_t  pal_nxt, pal_r;

  function automatic logic [7:0] expand5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // x / 3 for x < 768
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'd683;
    return p[18:11];
  endfunction

  // x / 5 for x < 1280
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd3277;
    return p[21:14];
  endfunction

  // x / 7 for x < 1792
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd2341;
    return p[21:14];
  endfunction

  // endpoint pair and weighted sums of a single-channel block
  function automatic vsum_t vbuild(input logic [15:0] w);
    vsum_t v;
    logic [10:0] w0;
    logic [10:0] w1;
    v.e0 = w[7:0];
    v.e1 = w[15:8];
    v.gt = v.e0 > v.e1;
    for (int i = 0; i < 6; i++) begin
      w1 = 11'(i + 1);
      w0 = v.gt ? 11'(6 - i) : 11'(4 - i);
      if (v.gt || i < 4) begin
        v.sum[i] = 11'(w0 * 11'(v.e0) + w1 * 11'(v.e1));
      end else begin
        v.sum[i] = '0;
      end
    end
    return v;
  endfunction

  // finished 8-entry palette
  function automatic logic [7:0][7:0] vfinish(input vsum_t v);
    logic [7:0][7:0] p;
    p[0] = v.e0;
    p[1] = v.e1;
    for (int i = 0; i < 6; i++) begin
      if (v.gt) begin
        p[2 + i] = div7(v.sum[i]);
      end else if (i < 4) begin
        p[2 + i] = div5(v.sum[i]);
      end else begin
        p[2 + i] = (i == 4) ? 8'd0 : 8'd255;
      end
    end
    return p;
  endfunction

  // stage 1: expansion and sums
  always_comb begin
    logic [31:0] cw;
    cw = (fmt == FMT_BC1) ? blk_lo[31:0] : blk_hi[31:0];
    sum_nxt.c.ep[0] = {expand5(cw[15:11]), expand6(cw[10:5]), expand5(cw[4:0])};
    sum_nxt.c.ep[1] = {expand5(cw[31:27]), expand6(cw[26:21]), expand5(cw[20:16])};
    sum_nxt.c.three = (fmt == FMT_BC1) && (cw[15:0] <= cw[31:16]);
    for (int s = 0; s < 3; s++) begin
      sum_nxt.c.s2[s] = {1'b0, sum_nxt.c.ep[0][s], 1'b0} + {2'b00, sum_nxt.c.ep[1][s]};
      sum_nxt.c.s3[s] = {2'b00, sum_nxt.c.ep[0][s]} + {1'b0, sum_nxt.c.ep[1][s], 1'b0};
    end
    sum_nxt.a = vbuild(blk_lo[15:0]);
    sum_nxt.g = vbuild(blk_hi[15:0]);
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      sum_r <= sum_nxt;
    end
  end

  // stage 2: divides and palette assembly
  always_comb begin
    logic [8:0] avg;
    pal_nxt.c.trans  = sum_r.c.three;
    pal_nxt.c.rgb[0] = sum_r.c.ep[0];
    pal_nxt.c.rgb[1] = sum_r.c.ep[1];
    for (int s = 0; s < 3; s++) begin
      avg = {1'b0, sum_r.c.ep[0][s]} + {1'b0, sum_r.c.ep[1][s]};
      if (sum_r.c.three) begin
        pal_nxt.c.rgb[2][8*s +: 8] = avg[8:1];
        pal_nxt.c.rgb[3][8*s +: 8] = 8'd0;
      end else begin
        pal_nxt.c.rgb[2][8*s +: 8] = div3(sum_r.c.s2[s]);
        pal_nxt.c.rgb[3][8*s +: 8] = div3(sum_r.c.s3[s]);
      end
    end
    pal_nxt.a = vfinish(sum_r.a);
    pal_nxt.g = vfinish(sum_r.g);
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      pal_r <= pal_nxt;
    end
  end

  assign pal = pal_r;

endmodule

`default_nettype wire

// ===== rtl/bctbd_lane.sv =====
// ----------------------------------------------------------------------------
// bctbd_lane
// One texel column: palette lookups and per-format ARGB assembly.
// ----------------------------------------------------------------------------
`default_nettype none

module bctbd_lane
  import bctbd_pkg::*;
(
  input  wire logic [2:0]  fmt,
  input  wire pal_t        pal,
  input  wire tidx_t       idx,
  output      logic [31:0] texel
);

  logic [23:0] rgb;
  logic [7:0]  calpha;
  logic [7:0]  av;
  logic [7:0]  gv;

  // lookups
  assign rgb    = pal.c.rgb[idx.cidx];
  assign calpha = (pal.c.trans && idx.cidx == 2'd3) ? 8'h00 : 8'hFF;
  assign av     = pal.a[idx.aidx];
  assign gv     = pal.g[idx.gidx];

  // format select
  always_comb begin
    unique case (fmt)
      FMT_BC1: texel = {calpha, rgb};
      FMT_BC2: texel = {idx.a4, idx.a4, rgb};
      FMT_BC3: texel = {av, rgb};
      FMT_BC4: texel = {8'hFF, av, av, av};
      FMT_BC5: texel = {8'hFF, av, gv, 8'h00};
      default: texel = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/bcn_texture_block_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// bcn_texture_block_decoder_unit
// BC1..BC5 block decoder: one 128-bit block in, four rows of ARGB8888 out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one compressed 4x4 block per item, block_low in tdata[63:0],
//           block_high in tdata[127:64].
//   out_* : four items per block, top row first; tlast marks the fourth row.
//   cfg_* : format code, written while the block is idle.
// Path: an accepted block passes the endpoint-sum register, the palette
//   register and the row stage before its first row enters the output register.
// Each block leaves as four rows through the single output row register;
//   the four column lanes finish a whole row each cycle unless out_tready stalls it.
// A new block is taken while the previous one is still emitting rows: the
//   two palette stages hold up to two blocks behind the row stage.
// When out_tready is low the output register holds its row and the stages
//   behind it fill up, then in_tready drops.
// Reset clears all valid flags and sets the format to BC1.
// ----------------------------------------------------------------------------
`default_nettype none

module bcn_texture_block_decoder_unit
  import bctbd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration
  input  wire logic              cfg_wr_en,
  input  wire logic [2:0]        cfg_wr_data,   // format_code
  // block input
  input  wire logic              in_tvalid,
  output      logic              in_tready,
  input  wire logic [IN_W-1:0]   in_tdata,      // block_low[63:0], block_high[127:64]
  // row output
  output      logic              out_tvalid,
  input  wire logic              out_tready,
  output      logic [OUT_W-1:0]  out_tdata,     // row_index[1:0], texel_zero[33:2],
                                                // texel_one[65:34], texel_two[97:66],
                                                // texel_three[129:98], zero pad
  output      logic              out_tlast      // last_row
);

  logic [2:0]             fmt_r;
  logic                   p1_vld_r, p2_vld_r, e_vld_r;
  logic [IN_W-1:0]        blk1_r, blk2_r, blke_r;
  logic [1:0]             row_r;
  pal_t                   pal2, pale_r;
  logic                   o_load, emit, e_free, e_take, p2_ready, p1_ready, in_fire;
  logic [63:0]            e_lo, e_hi;
  logic [31:0]            cw;
  tidx_t                  idx [LANES];
  logic [LANES-1:0][31:0] texel;
  logic                   out_tvalid_r, out_tlast_r;
  logic [OUT_W-1:0]       out_tdata_r, out_tdata_nxt;

  // format register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_BC1;
    end else if (cfg_wr_en) begin
      fmt_r <= cfg_wr_data;
    end
  end

  // pipeline flow control, back to front
  assign o_load   = !out_tvalid_r || out_tready;
  assign emit     = e_vld_r && o_load;
  assign e_free   = emit && (row_r == 2'd3);
  assign e_take   = !e_vld_r || e_free;
  assign p2_ready = !p2_vld_r || e_take;
  assign p1_ready = !p1_vld_r || p2_ready;
  assign in_fire  = in_tvalid && p1_ready;
  assign in_tready = p1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      e_vld_r  <= 1'b0;
      row_r    <= 2'd0;
    end else begin
      if (p1_ready) begin
        p1_vld_r <= in_tvalid;
      end
      if (p2_ready) begin
        p2_vld_r <= p1_vld_r;
      end
      if (e_take) begin
        e_vld_r <= p2_vld_r;
        row_r   <= 2'd0;
      end else if (emit) begin
        row_r   <= row_r + 2'd1;
      end
    end
  end

  // raw block travels beside the palette stages
  always_ff @(posedge clk) begin
    if (in_fire) begin
      blk1_r <= in_tdata;
    end
    if (p1_vld_r && p2_ready) begin
      blk2_r <= blk1_r;
    end
    if (p2_vld_r && e_take) begin
      blke_r <= blk2_r;
      pale_r <= pal2;
    end
  end

  bctbd_palette u_palette (
    .clk    (clk),
    .fmt    (fmt_r),
    .blk_lo (in_tdata[63:0]),
    .blk_hi (in_tdata[127:64]),
    .s1_en  (in_fire),
    .s2_en  (p1_vld_r && p2_ready),
    .pal    (pal2)
  );

  // column lanes on the current row
  assign e_lo = blke_r[63:0];
  assign e_hi = blke_r[127:64];
  assign cw   = (fmt_r == FMT_BC1) ? e_lo[63:32] : e_hi[63:32];

  for (genvar c = 0; c < LANES; c++) begin : g_lane
    logic [3:0] k;
    assign k = {row_r, 2'(c)};
    assign idx[c].cidx = cw[{k, 1'b0} +: 2];
    assign idx[c].a4   = e_lo[{k, 2'b00} +: 4];
    assign idx[c].aidx = e_lo[6'd16 + 6'(k) * 6'd3 +: 3];
    assign idx[c].gidx = e_hi[6'd16 + 6'(k) * 6'd3 +: 3];

    bctbd_lane u_lane (
      .fmt   (fmt_r),
      .pal   (pale_r),
      .idx   (idx[c]),
      .texel (texel[c])
    );
  end

  // merge lanes into the output row register
  assign out_tdata_nxt = OUT_W'({texel, row_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (o_load) begin
      out_tvalid_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_tdata_r <= out_tdata_nxt;
      out_tlast_r <= (row_r == 2'd3);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // checks
  a_row_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !e_vld_r |-> row_r == 2'd0)
    else $error("row counter not at zero while row stage is empty");

  a_block_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && row_r != 2'd3) |=> e_vld_r)
    else $error("block dropped before its fourth row");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_vld_r && p2_vld_r && e_vld_r && out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while the whole pipeline is stalled");

  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && row_r == 2'd3) |=> (out_tvalid && out_tlast && !e_vld_r) || p2_vld_r
                                 || $past(p2_vld_r))
    else $error("fourth row did not close the block");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the BC1..BC5 block decoder. Blocks are sent on the
// input stream, each accepted block is decoded by a behavioral predictor into
// four expected texel rows, and every row leaving the unit is compared field
// by field against the oldest expected row. Directed blocks cover endpoint
// order, palette modes and unused format codes; random blocks run under
// several sender/receiver idle patterns and format settings.
// ----------------------------------------------------------------------------

module testbench;
  import bctbd_pkg::*;

  // format codes the decoder treats as unused
  localparam logic [2:0] FMT_UNUSED5 = 3'd5;
  localparam logic [2:0] FMT_UNUSED6 = 3'd6;
  localparam logic [2:0] FMT_UNUSED7 = 3'd7;

  localparam int HANG_LIMIT  = 2000;   // cycles with no item moving
  localparam int BLOCKS_PER_FMT = 8;

  // one texel row: row index, four ARGB texels (column 0 in [0]), last flag
  typedef struct packed {
    logic [1:0]       row;
    logic [3:0][31:0] texel;
    logic             last;
  } texel_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [2:0]        cfg_wr_data = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;    // block_low[63:0], block_high[127:64]
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;        // row_index[1:0], texel_zero..texel_three
  logic              out_tlast;        // last_row

  texel_row_t expected_rows[$];
  logic [2:0] active_format = FMT_BC1;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         error_count = 0;
  int         quiet_cycles = 0;

  bcn_texture_block_decoder_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // 565 endpoint to 888 by bit replication
  function automatic logic [23:0] expand565(input logic [15:0] e);
    return {e[15:11], e[15:13], e[10:5], e[10:9], e[4:0], e[4:2]};
  endfunction

  // four-entry color palette; three-color mode only where allowed
  function automatic void build_colors(input logic [63:0] w, input bit allow_three,
                                       output logic [3:0][31:0] pal);
    logic [23:0] c0, c1;
    int x0, x1;
    c0 = expand565(w[15:0]);
    c1 = expand565(w[31:16]);
    pal[0] = {8'hFF, c0};
    pal[1] = {8'hFF, c1};
    pal[2] = 32'hFF00_0000;
    pal[3] = 32'hFF00_0000;
    if (w[15:0] > w[31:16] || !allow_three) begin
      for (int s = 0; s < 3; s++) begin
        x0 = int'(c0[8*s +: 8]);
        x1 = int'(c1[8*s +: 8]);
        pal[2][8*s +: 8] = 8'((2 * x0 + x1) / 3);
        pal[3][8*s +: 8] = 8'((x0 + 2 * x1) / 3);
      end
    end else begin
      for (int s = 0; s < 3; s++) begin
        x0 = int'(c0[8*s +: 8]);
        x1 = int'(c1[8*s +: 8]);
        pal[2][8*s +: 8] = 8'((x0 + x1) >> 1);
      end
      pal[3] = 32'h0000_0000;   // transparent black
    end
  endfunction

  // eight-entry single channel palette from the low two bytes
  function automatic void build_values(input logic [63:0] w, output logic [7:0][7:0] pal);
    int a0, a1;
    a0 = int'(w[7:0]);
    a1 = int'(w[15:8]);
    pal[0] = w[7:0];
    pal[1] = w[15:8];
    if (a0 > a1) begin
      for (int i = 0; i < 6; i++)
        pal[2+i] = 8'(((6 - i) * a0 + (1 + i) * a1) / 7);
    end else begin
      for (int i = 0; i < 4; i++)
        pal[2+i] = 8'(((4 - i) * a0 + (1 + i) * a1) / 5);
      pal[6] = 8'd0;
      pal[7] = 8'd255;
    end
  endfunction

  // decode one block under the current format and queue its four rows
  function automatic void predict_rows(input logic [2:0] fmt, input logic [63:0] lo,
                                       input logic [63:0] hi);
    logic [3:0][31:0]  cpal;
    logic [7:0][7:0]   apal, gpal;
    logic [15:0][31:0] tex;
    logic [1:0]        ci;
    logic [2:0]        ai, gi;
    int                alpha;
    texel_row_t        r;
    build_colors((fmt == FMT_BC1) ? lo : hi, fmt == FMT_BC1, cpal);
    build_values(lo, apal);
    build_values(hi, gpal);
    for (int k = 0; k < 16; k++) begin
      ci = (fmt == FMT_BC1) ? lo[32 + 2*k +: 2] : hi[32 + 2*k +: 2];
      ai = lo[16 + 3*k +: 3];
      gi = hi[16 + 3*k +: 3];
      case (fmt)
        FMT_BC1: tex[k] = cpal[ci];
        FMT_BC2: begin
          alpha = int'(lo[4*k +: 4]) * 17;
          tex[k] = {8'(alpha), cpal[ci][23:0]};
        end
        FMT_BC3: tex[k] = {apal[ai], cpal[ci][23:0]};
        FMT_BC4: tex[k] = {8'hFF, apal[ai], apal[ai], apal[ai]};
        FMT_BC5: tex[k] = {8'hFF, apal[ai], gpal[gi], 8'h00};
        default: tex[k] = 32'h0;
      endcase
    end
    for (int row = 0; row < 4; row++) begin
      r.row   = 2'(row);
      r.texel = tex[4*row +: 4];
      r.last  = (row == 3);
      expected_rows.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Row checker and receiver stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    texel_row_t exp_row;
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_rows.size() == 0) begin
        $error("row_index: unexpected row, got %0d", out_tdata[1:0]);
        error_count++;
      end else begin
        exp_row = expected_rows.pop_front();
        if (out_tdata[1:0] !== exp_row.row) begin
          $error("row_index: expected %0d got %0d", exp_row.row, out_tdata[1:0]);
          error_count++;
        end
        if (out_tdata[33:2] !== exp_row.texel[0]) begin
          $error("texel_zero: expected %h got %h", exp_row.texel[0], out_tdata[33:2]);
          error_count++;
        end
        if (out_tdata[65:34] !== exp_row.texel[1]) begin
          $error("texel_one: expected %h got %h", exp_row.texel[1], out_tdata[65:34]);
          error_count++;
        end
        if (out_tdata[97:66] !== exp_row.texel[2]) begin
          $error("texel_two: expected %h got %h", exp_row.texel[2], out_tdata[97:66]);
          error_count++;
        end
        if (out_tdata[129:98] !== exp_row.texel[3]) begin
          $error("texel_three: expected %h got %h", exp_row.texel[3], out_tdata[129:98]);
          error_count++;
        end
        if (out_tlast !== exp_row.last) begin
          $error("last_row: expected %0d got %0d", exp_row.last, out_tlast);
          error_count++;
        end
      end
    end
  end

  // hang detection: no item moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // send one block; valid stays high after acceptance unless a gap follows
  task automatic send_block(input logic [63:0] lo, input logic [63:0] hi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {hi, lo};
    do @(posedge clk); while (!in_tready);
    predict_rows(active_format, lo, hi);
  endtask

  // stop sending and wait for every pending row
  task automatic drain_rows();
    in_tvalid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
  endtask

  task automatic set_format(input logic [2:0] fmt);
    drain_rows();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= fmt;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    active_format = fmt;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // endpoint order picks four- or three-color mode; equal endpoints are 3-color
  task automatic test_bc1();
    set_format(FMT_BC1);
    send_block(64'h0, 64'h0);
    send_block('1, '1);
    send_block({32'hE4E4_E4E4, 16'h07E0, 16'hF800}, rand64());
    send_block({32'hE4E4_E4E4, 16'hF81F, 16'h001F}, rand64());
    send_block({32'h1B1B_1B1B, 16'h1234, 16'hFEDC}, rand64());
  endtask

  // explicit alpha, every nibble value; color half always four-color
  task automatic test_bc2();
    set_format(FMT_BC2);
    send_block(64'hFEDC_BA98_7654_3210, {32'hE4E4_E4E4, 16'hF800, 16'h07E0});
    send_block('1, '1);
  endtask

  // interpolated alpha in both palette modes, all eight indices
  task automatic test_bc3();
    set_format(FMT_BC3);
    send_block({48'hFAC6_88FA_C688, 8'h10, 8'hF0}, {32'hE4E4_E4E4, 16'hFFFF, 16'h0000});
    send_block({48'hFAC6_88FA_C688, 8'hC0, 8'h40}, {32'h4E4E_4E4E, 16'h8410, 16'h4208});
    send_block(64'h0, '1);
  endtask

  task automatic test_bc4();
    set_format(FMT_BC4);
    send_block({48'hFAC6_88FA_C688, 8'h00, 8'hFF}, rand64());
    send_block({48'hFAC6_88FA_C688, 8'hFF, 8'h00}, rand64());
    send_block('1, 64'h0);
  endtask

  task automatic test_bc5();
    set_format(FMT_BC5);
    send_block({48'hFAC6_88FA_C688, 8'h21, 8'hE7}, {48'hFAC6_88FA_C688, 8'hD0, 8'h33});
    send_block({48'hFAC6_88FA_C688, 8'hD0, 8'h33}, {48'hFAC6_88FA_C688, 8'h21, 8'hE7});
    send_block(64'h0, 64'h0);
  endtask

  // unused codes still give four rows of zero texels
  task automatic test_unused_formats();
    set_format(FMT_UNUSED5);
    send_block(rand64(), rand64());
    set_format(FMT_UNUSED6);
    send_block(rand64(), rand64());
    set_format(FMT_UNUSED7);
    send_block('1, '1);
  endtask

  // random blocks under one idle pattern, format stepping from first_fmt, one code per group
  task automatic test_random(input int idle_pct, input int stall_pct, input int groups,
                             input int first_fmt);
    logic [63:0] lo, hi;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int grp = 0; grp < groups; grp++) begin
      set_format(3'((first_fmt + grp) % 8));
      for (int n = 0; n < BLOCKS_PER_FMT; n++) begin
        lo = rand64();
        hi = rand64();
        // equal endpoints now and then
        if ($urandom_range(5) == 0) begin
          lo[31:16] = lo[15:0];
          hi[31:16] = hi[15:0];
          lo[15:8]  = lo[7:0];
          hi[15:8]  = hi[7:0];
        end
        send_block(lo, hi);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_bc1();
    test_bc2();
    test_bc3();
    test_bc4();
    test_bc5();
    test_unused_formats();

    test_random(0, 0, 5, 0);
    test_random(78, 0, 5, 5);
    test_random(0, 78, 5, 2);
    test_random(17, 17, 5, 7);

    drain_rows();
    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bctbd_pkg.sv
rtl/bctbd_palette.sv
rtl/bctbd_lane.sv
rtl/bcn_texture_block_decoder_unit.sv
test/testbench.sv
